@@ design/keyframe_vec3_ease_interp_top_assert.svh @@
// Assertion macros for the keyframe interpolator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef KEYFRAME_VEC3_EASE_INTERP_TOP_ASSERT_SVH
`define KEYFRAME_VEC3_EASE_INTERP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KVEI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KVEI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/kvei_pkg.sv @@
// Shared types, constants and the sine table function of the keyframe interpolator.
// No dependencies.
package kvei_pkg;

	localparam int MAX_KEYS_DEF  = 64;
	localparam int SINE_BITS_DEF = 10;
	localparam int SINE_W        = 17;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic {OP_WRITE, OP_SAMPLE} opcode_t;
	typedef enum logic {REG_KEY_COUNT, REG_EMPTY_FILL} cfg_reg_t;
	typedef enum logic [1:0] {CURVE_LINEAR, CURVE_IN, CURVE_OUT, CURVE_INOUT} curve_t;
	typedef enum logic [2:0] {OC_INTERP, OC_BEFORE, OC_AFTER, OC_SINGLE, OC_EMPTY} outcome_t;

	typedef struct packed {
		logic [1:0]         curve;
		logic signed [31:0] pz;
		logic signed [31:0] py;
		logic signed [31:0] px;
		logic [31:0]        stamp;
	} entry_t;

	typedef struct packed {
		logic     accept;
		logic     scan_init;
		logic     scan_adv;
		logic     hold;
		logic     fill;
		logic     div_init;
		logic     div_step;
		logic     rom_hi;
		logic     ease_cap;
		logic     mul;
		logic     add;
		logic [1:0] axis;
		logic     out_load;
		outcome_t outcome;
	} cmd_t;

	typedef struct packed {
		logic is_write;
		logic n_zero;
		logic n_one;
		logic gt;
		logic first;
		logic last;
	} stat_t;

	// Quarter-sine entry in Q16, integer Taylor series, evaluated at elaboration.
	function automatic logic [16:0] sine_entry(input int idx, input int bits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] q;
		x    = (HALF_PI_Q30 * 64'(idx)) >> bits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		for (int k = 1; k <= 6; k++) begin
			term = (term * x2) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k[0])
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 0)
			sum = 0;
		q = (sum + 64'sd8192) >>> 14;
		if (q > 64'sd65536)
			q = 64'sd65536;
		return q[16:0];
	endfunction

endpackage

@@ design/kvei_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kvei_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/kvei_ctrl.sv @@
// Sequencer of the keyframe interpolator: search, divide, ease, lerp, hand-off.
// Depends on kvei_pkg.
module kvei_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  kvei_pkg::stat_t stat,
	output kvei_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		IDLE, SCAN_RD, SCAN_CMP, DIV, SIN_LO, SIN_HI, SIN_CAP, MUL, ADD, DONE
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [3:0] cnt_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.outcome = kvei_pkg::OC_INTERP;
		cmd.axis    = cnt_q[1:0];
		state_d     = state_q;
		case (state_q)
			IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && !stat.is_write) begin
					if (stat.n_zero) begin
						cmd.fill = 1'b1;
						state_d  = DONE;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = SCAN_RD;
					end
				end
			end
			SCAN_RD: state_d = SCAN_CMP;
			SCAN_CMP: begin
				if (stat.n_one) begin
					cmd.hold    = 1'b1;
					cmd.outcome = kvei_pkg::OC_SINGLE;
					state_d     = DONE;
				end else if (stat.gt && stat.first) begin
					cmd.hold    = 1'b1;
					cmd.outcome = kvei_pkg::OC_BEFORE;
					state_d     = DONE;
				end else if (stat.gt) begin
					cmd.div_init = 1'b1;
					state_d      = DIV;
				end else if (stat.last) begin
					cmd.hold    = 1'b1;
					cmd.outcome = kvei_pkg::OC_AFTER;
					state_d     = DONE;
				end else begin
					cmd.scan_adv = 1'b1;
					state_d      = SCAN_RD;
				end
			end
			DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 4'd15)
					state_d = SIN_LO;
			end
			SIN_LO: state_d = SIN_HI;
			SIN_HI: begin
				cmd.rom_hi = 1'b1;
				state_d    = SIN_CAP;
			end
			SIN_CAP: begin
				cmd.ease_cap = 1'b1;
				state_d      = MUL;
			end
			MUL: begin
				cmd.mul = 1'b1;
				state_d = ADD;
			end
			ADD: begin
				cmd.add = 1'b1;
				state_d = (cnt_q == 4'd2) ? DONE : MUL;
			end
			DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init || cmd.ease_cap)
				cnt_q <= '0;
			else if (cmd.div_step || cmd.add)
				cnt_q <= cnt_q + 4'd1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ design/kvei_dp.sv @@
// Datapath of the keyframe interpolator: key table, divider, sine easing, lerp.
// Depends on kvei_pkg and kvei_ram.
module kvei_dp #(
	parameter int MAX_KEYS        = kvei_pkg::MAX_KEYS_DEF,
	parameter int SINE_TABLE_BITS = kvei_pkg::SINE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic            in_tuser,
	input  logic [167:0]    in_tdata,
	input  kvei_pkg::cmd_t  cmd,
	output kvei_pkg::stat_t stat,
	output logic [103:0]    out_tdata,
	output logic [2:0]      out_tuser
);

	localparam int AW    = $clog2(MAX_KEYS);
	localparam int TBL_N = 1 << SINE_TABLE_BITS;
	localparam int TW    = SINE_TABLE_BITS + 1;
	localparam int SH    = 16 - SINE_TABLE_BITS;
	localparam int EW    = $bits(kvei_pkg::entry_t);

	logic [6:0]         key_count_q;
	logic [31:0]        fill_q;
	logic [6:0]         n_keys;
	logic [6:0]         idx_q;
	logic [31:0]        t_q;
	kvei_pkg::entry_t   wr_e;
	kvei_pkg::entry_t   rd_e;
	kvei_pkg::entry_t   prev_q;
	kvei_pkg::entry_t   cur_q;
	logic [EW-1:0]      rdata;
	logic [5:0]         slot;
	logic [31:0]        slot_ext;
	logic [31:0]        idx_ext;
	logic               ram_we;
	logic [32:0]        rem_q;
	logic [31:0]        den_q;
	logic [15:0]        quo_q;
	logic [32:0]        rem_sh;
	logic [16:0]        phase;
	logic [16:0]        p2;
	logic [TW-1:0]      lo_idx;
	logic [TW-1:0]      hi_idx;
	logic [TW-1:0]      rom_addr;
	logic [SH-1:0]      frac;
	logic [16:0]        sine_rom [TBL_N+1];
	logic [16:0]        rom_q;
	logic [16:0]        lo_q;
	logic signed [17:0] sdiff;
	logic signed [SH+18:0] sprod;
	logic signed [SH+18:0] sshift;
	logic [16:0]        sval;
	logic [17:0]        s_up;
	logic [16:0]        e_d;
	logic [16:0]        e_q;
	logic signed [31:0] ax_a;
	logic signed [31:0] ax_b;
	logic signed [50:0] prod_q;
	logic signed [34:0] prod_sh;
	logic signed [35:0] lsum;
	logic signed [31:0] lsat;
	logic signed [31:0] res_q [3];
	logic [5:0]         seg_q;
	kvei_pkg::outcome_t oc_q;
	logic [95:0]        out_vals_q;
	logic [5:0]         out_seg_q;
	kvei_pkg::outcome_t out_oc_q;

	// Oversized counts behave as a full table.
	assign n_keys = (32'(key_count_q) > MAX_KEYS) ? 7'(MAX_KEYS) : key_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			fill_q      <= '0;
		end else if (cfg_we) begin
			case (kvei_pkg::cfg_reg_t'(cfg_index))
				kvei_pkg::REG_KEY_COUNT:  key_count_q <= cfg_data[6:0];
				kvei_pkg::REG_EMPTY_FILL: fill_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign slot        = in_tdata[5:0];
	assign wr_e.stamp  = in_tdata[37:6];
	assign wr_e.px     = in_tdata[69:38];
	assign wr_e.py     = in_tdata[101:70];
	assign wr_e.pz     = in_tdata[133:102];
	assign wr_e.curve  = in_tdata[135:134];
	assign slot_ext    = 32'(slot);
	assign idx_ext     = 32'(idx_q);
	assign ram_we      = cmd.accept && (in_tuser == kvei_pkg::OP_WRITE)
		&& (slot_ext < MAX_KEYS);

	kvei_ram #(.WIDTH(EW), .DEPTH(MAX_KEYS)) u_keys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_ext[AW-1:0]),
		.wdata (wr_e),
		.raddr (idx_ext[AW-1:0]),
		.rdata (rdata)
	);
	assign rd_e = kvei_pkg::entry_t'(rdata);

	assign stat.is_write = (in_tuser == kvei_pkg::OP_WRITE);
	assign stat.n_zero   = (n_keys == 7'd0);
	assign stat.n_one    = (n_keys == 7'd1);
	assign stat.gt       = (rd_e.stamp > t_q);
	assign stat.first    = (idx_q == 7'd0);
	assign stat.last     = (idx_q == n_keys - 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (cmd.scan_init)
			idx_q <= '0;
		else if (cmd.scan_adv)
			idx_q <= idx_q + 7'd1;
	end

	// Restoring division, one quotient bit per cycle; the dividend is below the divisor.
	assign rem_sh = {rem_q[31:0], 1'b0};

	// Easing phase and quarter-sine table addresses.
	assign p2 = {quo_q, 1'b0};
	always_comb begin
		case (kvei_pkg::curve_t'(cur_q.curve))
			kvei_pkg::CURVE_IN:    phase = 17'd65536 - {1'b0, quo_q};
			kvei_pkg::CURVE_INOUT: phase = quo_q[15] ? (p2 - 17'd65536) : (17'd65536 - p2);
			default:               phase = {1'b0, quo_q};
		endcase
	end
	assign lo_idx   = phase[16] ? TW'(TBL_N) : {1'b0, phase[15:SH]};
	assign hi_idx   = phase[16] ? TW'(TBL_N) : lo_idx + TW'(1);
	assign frac     = phase[16] ? '0 : phase[SH-1:0];
	assign rom_addr = cmd.rom_hi ? hi_idx : lo_idx;

	for (genvar g = 0; g <= TBL_N; g++) begin : g_sine
		assign sine_rom[g] = kvei_pkg::sine_entry(g, SINE_TABLE_BITS);
	end

	assign sdiff  = $signed({1'b0, rom_q}) - $signed({1'b0, lo_q});
	assign sprod  = sdiff * $signed({1'b0, frac});
	assign sshift = sprod >>> SH;
	assign sval   = lo_q + sshift[16:0];
	assign s_up   = 18'd65536 + {1'b0, sval};

	always_comb begin
		case (kvei_pkg::curve_t'(cur_q.curve))
			kvei_pkg::CURVE_IN:    e_d = 17'd65536 - sval;
			kvei_pkg::CURVE_OUT:   e_d = sval;
			kvei_pkg::CURVE_INOUT: begin
				if (quo_q[15])
					e_d = s_up[17:1];
				else
					e_d = (17'd65536 - sval) >> 1;
			end
			default:               e_d = {1'b0, quo_q};
		endcase
	end

	// Lerp, one axis at a time through a shared multiplier.
	always_comb begin
		case (cmd.axis)
			2'd0:    begin ax_a = prev_q.px; ax_b = cur_q.px; end
			2'd1:    begin ax_a = prev_q.py; ax_b = cur_q.py; end
			default: begin ax_a = prev_q.pz; ax_b = cur_q.pz; end
		endcase
	end
	assign prod_sh = 35'(prod_q >>> 16);
	assign lsum    = 36'(ax_a) + 36'(prod_sh);
	assign lsat    = (lsum > 36'sd2147483647) ? 32'sh7FFFFFFF :
		(lsum < -36'sd2147483648) ? 32'sh80000000 : lsum[31:0];

	always_ff @(posedge clk) begin
		rom_q <= sine_rom[rom_addr];
		if (cmd.accept)
			t_q <= in_tdata[167:136];
		if (cmd.scan_adv)
			prev_q <= rd_e;
		if (cmd.hold) begin
			res_q[0] <= rd_e.px;
			res_q[1] <= rd_e.py;
			res_q[2] <= rd_e.pz;
			seg_q    <= idx_q[5:0];
			oc_q     <= cmd.outcome;
		end
		if (cmd.fill) begin
			res_q[0] <= fill_q;
			res_q[1] <= fill_q;
			res_q[2] <= fill_q;
			seg_q    <= '0;
			oc_q     <= kvei_pkg::OC_EMPTY;
		end
		if (cmd.div_init) begin
			cur_q <= rd_e;
			rem_q <= {1'b0, t_q - prev_q.stamp};
			den_q <= rd_e.stamp - prev_q.stamp;
			quo_q <= '0;
			seg_q <= idx_q[5:0];
			oc_q  <= kvei_pkg::OC_INTERP;
		end
		if (cmd.div_step) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
		if (cmd.rom_hi)
			lo_q <= rom_q;
		if (cmd.ease_cap)
			e_q <= e_d;
		if (cmd.mul)
			prod_q <= ($signed({ax_b[31], ax_b}) - $signed({ax_a[31], ax_a}))
				* $signed({1'b0, e_q});
		if (cmd.add)
			res_q[cmd.axis] <= lsat;
		if (cmd.out_load) begin
			out_vals_q <= {res_q[2], res_q[1], res_q[0]};
			out_seg_q  <= seg_q;
			out_oc_q   <= oc_q;
		end
	end

	assign out_tdata = {2'b00, out_seg_q, out_vals_q};
	assign out_tuser = out_oc_q;

endmodule

@@ design/keyframe_vec3_ease_interp_top.sv @@
// Keyframe table with eased linear interpolation on three axes, Q16.16.
// Channels: s_axis carries write and sample items (tuser is the opcode),
// m_axis carries one result per sample item (tuser is the outcome code).
// A write item is stored in the cycle it is accepted and gives no result.
// A sample item scans the table, reading and comparing one key at a time,
// then runs the fraction divider, the sine table lookup (low entry, high
// entry, capture) and the lerp of the three axes through one shared
// multiplier, then hands the result off to the output register; the next
// item is taken once the result has been handed off.
// Held cases finish straight after the scan; an empty table goes straight
// to the hand-off without a scan.
// s_axis_tready is high whenever no sample is in progress; a finished item
// waits in the output register, so a new item is accepted meanwhile, and
// the next result waits until the receiver takes the previous one.
// Reset clears the registers (key_count 0, empty_fill 0) and the handshake;
// the key table itself holds nothing defined until written.
// Depends on kvei_pkg, kvei_ram, kvei_ctrl and kvei_dp.
`include "keyframe_vec3_ease_interp_top_assert.svh"
module keyframe_vec3_ease_interp_top #(
	parameter int MAX_KEYS        = kvei_pkg::MAX_KEYS_DEF,
	parameter int SINE_TABLE_BITS = kvei_pkg::SINE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// key_slot, key_stamp, key_px, key_py, key_pz, key_curve, sample_stamp
	input  logic [167:0] s_axis_tdata,
	// opcode
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_px, out_py, out_pz, segment_end, zero padding
	output logic [103:0] m_axis_tdata,
	// outcome
	output logic [2:0]   m_axis_tuser
);

	kvei_pkg::cmd_t  cmd;
	kvei_pkg::stat_t stat;

	kvei_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	kvei_dp #(.MAX_KEYS(MAX_KEYS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_tuser  (s_axis_tuser),
		.in_tdata  (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser)
	);

	`KVEI_ASSERT_SAME(a_load_when_free, cmd.out_load, !m_axis_tvalid || m_axis_tready, "result loaded over a waiting item")
	`KVEI_ASSERT_NEXT(a_write_silent, s_axis_tvalid && s_axis_tready && (s_axis_tuser == kvei_pkg::OP_WRITE) && !m_axis_tvalid, !m_axis_tvalid, "write item produced a result")
	`KVEI_ASSERT_SAME(a_empty_seg, m_axis_tvalid && (m_axis_tuser == kvei_pkg::OC_EMPTY), m_axis_tdata[101:96] == 6'd0, "empty result with non-zero segment")

endmodule
